// ----- rtl/pooled_doubly_linked_deque_defines.svh -----
// ----------------------------------------------------------------------------
// pooled doubly linked deque - assertion macros
// shared checking helpers for the deque rtl
// ----------------------------------------------------------------------------
`ifndef POOLED_DOUBLY_LINKED_DEQUE_DEFINES_SVH
`define POOLED_DOUBLY_LINKED_DEQUE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PDLQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PDLQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pdlq_pkg.sv -----
// ----------------------------------------------------------------------------
// pdlq_pkg
// types and codes of the pooled doubly linked deque
// ----------------------------------------------------------------------------
`default_nettype none

package pdlq_pkg;

	// request function codes
	typedef enum logic [2:0] {
		FN_PUSH_HEAD = 3'd0,
		FN_PUSH_TAIL = 3'd1,
		FN_POP_HEAD  = 3'd2,
		FN_POP_TAIL  = 3'd3,
		FN_REMOVE    = 3'd4
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_BAD_SLOT = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_LINK,
		ST_UNL_P,
		ST_UNL_N,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/pooled_doubly_linked_deque.sv -----
// ----------------------------------------------------------------------------
// pooled_doubly_linked_deque
// doubly linked deque kept in a fixed pool of slots held in one node memory
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid / in_stall) carries one request: func, value_in,
//   slot_sel; a request is taken when in_valid is high and in_stall is low
// - output channel (out_valid / out_stall) returns exactly one result per
//   request: status, value_out, slot_used, entry_count, head_slot, tail_slot
// - one request is worked at a time, so a new request is taken only after
//   the last one is through; all node state sits in a single memory with a
//   registered read, so each link update is a read then a write-back
// - rejected and unknown requests pass only the exec and done states; pop
//   and remove add an unlink state for each neighbor link, and a push adds
//   the link state when an old end node exists, then the free-slot scan; the
//   scan reads one slot per cycle and is skipped when the pool fills
// - a finished result waits in the output register while out_stall is high;
//   the next request is taken meanwhile, and its result waits until the
//   output register is free
// - after reset the block sweeps every slot of the node memory, holding
//   in_stall high, then lists are empty and the free hint is slot 0
// ----------------------------------------------------------------------------
`default_nettype none

module pooled_doubly_linked_deque #(
	parameter int NODE_COUNT  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          func,
	input  wire logic signed [31:0]  value_in,
	input  wire logic [3:0]          slot_sel,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output pdlq_pkg::status_t        status,
	output logic signed [31:0]       value_out,
	output logic [3:0]               slot_used,
	output logic [4:0]               entry_count,
	output logic signed [4:0]        head_slot,
	output logic signed [4:0]        tail_slot
);

	import pdlq_pkg::*;

	`include "pooled_doubly_linked_deque_defines.svh"

	localparam int IW = $clog2(NODE_COUNT);
	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

	// a link is a slot index plus a flag for "no slot"
	typedef struct packed {
		logic          none;
		logic [IW-1:0] idx;
	} link_t;

	// one node of the pool
	typedef struct packed {
		logic                   busy;
		logic [VALUE_WIDTH-1:0] value;
		link_t                  prev;
		link_t                  next;
	} entry_t;

	localparam link_t  LINK_NONE   = '{none: 1'b1, idx: '0};
	localparam entry_t ENTRY_CLEAR = '{busy: 1'b0, value: '0, prev: LINK_NONE,
		next: LINK_NONE};

	// circular step to the next slot
	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		logic [IW-1:0] r;
		if (i == IW'(NODE_COUNT - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	// node memory
	entry_t        mem [NODE_COUNT];
	entry_t        rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	// control state
	state_t        state_q, state_d;
	logic [IW-1:0] clr_idx_q, clr_idx_d;
	link_t         head_q, head_d;
	link_t         tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] hint_q, hint_d;
	logic [IW-1:0] scan_idx_q, scan_idx_d;
	logic          out_valid_q, out_valid_d;

	// request and working payload
	logic [2:0]    func_q, func_d;
	logic [31:0]   value_q, value_d;
	logic [3:0]    sel_q, sel_d;
	entry_t        node_q, node_d;
	logic [IW-1:0] nb_idx_q, nb_idx_d;
	status_t       res_status_q, res_status_d;
	logic [31:0]   res_value_q, res_value_d;
	logic [IW-1:0] res_slot_q, res_slot_d;

	// output register payload
	status_t       out_status_q, out_status_d;
	logic [31:0]   out_value_q, out_value_d;
	logic [3:0]    out_slot_q, out_slot_d;
	logic [4:0]    out_count_q, out_count_d;
	logic [4:0]    out_head_q, out_head_d;
	logic [4:0]    out_tail_q, out_tail_d;

	// next state and memory access
	always_comb begin
		logic          at_head;
		logic          is_pop;
		logic [IW-1:0] s;
		link_t         nb;
		link_t         tgt;
		entry_t        fresh;
		entry_t        upd;
		logic [EW-1:0] ext;
		logic          rejected;
		logic [CW-1:0] count_dec;

		at_head   = 1'b0;
		is_pop    = 1'b0;
		s         = '0;
		nb        = LINK_NONE;
		tgt       = LINK_NONE;
		fresh     = ENTRY_CLEAR;
		upd       = ENTRY_CLEAR;
		ext       = '0;
		rejected  = 1'b0;
		count_dec = '0;

		state_d      = state_q;
		clr_idx_d    = clr_idx_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		hint_d       = hint_q;
		scan_idx_d   = scan_idx_q;
		func_d       = func_q;
		value_d      = value_q;
		sel_d        = sel_q;
		node_d       = node_q;
		nb_idx_d     = nb_idx_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_slot_d   = res_slot_q;
		out_status_d = out_status_q;
		out_value_d  = out_value_q;
		out_slot_d   = out_slot_q;
		out_count_d  = out_count_q;
		out_head_d   = out_head_q;
		out_tail_d   = out_tail_q;

		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = ENTRY_CLEAR;

		in_stall = (state_q != ST_IDLE);

		// result taken by the receiver
		out_valid_d = out_valid_q && out_stall;

		case (state_q)
			ST_CLEAR: begin
				// sweep every slot to the empty node after reset
				wr_en     = 1'b1;
				wr_addr   = clr_idx_q;
				wr_data   = ENTRY_CLEAR;
				clr_idx_d = next_idx(clr_idx_q);
				if (clr_idx_q == IW'(NODE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				// fetch the node the request acts on
				case (func)
					FN_PUSH_HEAD, FN_POP_HEAD: rd_addr = head_q.idx;
					FN_PUSH_TAIL, FN_POP_TAIL: rd_addr = tail_q.idx;
					FN_REMOVE:                 rd_addr = IW'(slot_sel);
					default:                   rd_addr = '0;
				endcase
				if (in_valid) begin
					func_d  = func;
					value_d = value_in;
					sel_d   = slot_sel;
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				res_status_d = STAT_OK;
				res_value_d  = '0;
				res_slot_d   = '0;
				state_d      = ST_DONE;
				if (func_q inside {FN_PUSH_HEAD, FN_PUSH_TAIL}) begin
					at_head = (func_q == FN_PUSH_HEAD);
					if (count_q == CW'(NODE_COUNT)) begin
						res_status_d = STAT_FULL;
					end else begin
						// new node goes into the hinted free slot
						s           = hint_q;
						nb          = at_head ? head_q : tail_q;
						fresh.busy  = 1'b1;
						fresh.value = VALUE_WIDTH'(value_q);
						fresh.prev  = at_head ? LINK_NONE : tail_q;
						fresh.next  = at_head ? head_q : LINK_NONE;
						wr_en       = 1'b1;
						wr_addr     = s;
						wr_data     = fresh;

						if (at_head || head_q.none) begin
							head_d = '{none: 1'b0, idx: s};
						end
						if (!at_head || tail_q.none) begin
							tail_d = '{none: 1'b0, idx: s};
						end
						count_d    = count_q + 1'b1;
						hint_d     = s;
						res_slot_d = s;

						// old end node gets its link to the new one
						upd = rd_q;
						if (at_head) begin
							upd.prev = '{none: 1'b0, idx: s};
						end else begin
							upd.next = '{none: 1'b0, idx: s};
						end
						node_d   = upd;
						nb_idx_d = nb.idx;

						if (!nb.none) begin
							state_d = ST_LINK;
						end else if (count_q != CW'(NODE_COUNT - 1)) begin
							rd_addr    = next_idx(s);
							scan_idx_d = next_idx(s);
							state_d    = ST_SCAN;
						end
					end
				end else if (func_q inside {FN_POP_HEAD, FN_POP_TAIL, FN_REMOVE}) begin
					is_pop = (func_q != FN_REMOVE);
					case (func_q)
						FN_POP_HEAD: tgt = head_q;
						FN_POP_TAIL: tgt = tail_q;
						default:     tgt = '{none: 1'b0, idx: IW'(sel_q)};
					endcase
					s = tgt.idx;
					if (is_pop) begin
						rejected = (count_q == '0) || tgt.none || !rd_q.busy;
					end else begin
						rejected = (32'(sel_q) >= 32'(NODE_COUNT)) || !rd_q.busy;
					end

					if (rejected) begin
						res_status_d = is_pop ? STAT_EMPTY : STAT_BAD_SLOT;
					end else begin
						// keep the node for its links, release the slot
						node_d  = rd_q;
						wr_en   = 1'b1;
						wr_addr = s;
						wr_data = ENTRY_CLEAR;

						if (!head_q.none && head_q.idx == s) begin
							head_d = rd_q.next;
						end
						if (!tail_q.none && tail_q.idx == s) begin
							tail_d = rd_q.prev;
						end
						count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;
						count_d   = count_dec;
						if (count_dec == '0) begin
							hint_d = '0;
							head_d = LINK_NONE;
							tail_d = LINK_NONE;
						end else begin
							hint_d = s;
						end

						res_slot_d = s;
						if (is_pop) begin
							ext         = EW'($signed(rd_q.value));
							res_value_d = ext[31:0];
						end

						if (!rd_q.prev.none) begin
							rd_addr = rd_q.prev.idx;
							state_d = ST_UNL_P;
						end else if (!rd_q.next.none) begin
							rd_addr = rd_q.next.idx;
							state_d = ST_UNL_N;
						end
					end
				end
			end

			ST_LINK: begin
				// write back the old end node, then, unless the pool is full, look for the next free slot
				wr_en   = 1'b1;
				wr_addr = nb_idx_q;
				wr_data = node_q;
				if (count_q != CW'(NODE_COUNT)) begin
					rd_addr    = next_idx(hint_q);
					scan_idx_d = next_idx(hint_q);
					state_d    = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end

			ST_UNL_P: begin
				// predecessor now points past the released node
				upd      = rd_q;
				upd.next = node_q.next;
				wr_en    = 1'b1;
				wr_addr  = node_q.prev.idx;
				wr_data  = upd;
				if (!node_q.next.none) begin
					rd_addr = node_q.next.idx;
					state_d = ST_UNL_N;
				end else begin
					state_d = ST_DONE;
				end
			end

			ST_UNL_N: begin
				// successor now points back past the released node
				upd      = rd_q;
				upd.prev = node_q.prev;
				wr_en    = 1'b1;
				wr_addr  = node_q.next.idx;
				wr_data  = upd;
				state_d  = ST_DONE;
			end

			ST_SCAN: begin
				// one slot per cycle, circular upward from the pushed slot
				if (!rd_q.busy) begin
					hint_d  = scan_idx_q;
					state_d = ST_DONE;
				end else begin
					rd_addr    = next_idx(scan_idx_q);
					scan_idx_d = next_idx(scan_idx_q);
				end
			end

			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_value_d  = res_value_q;
					out_slot_d   = 4'(res_slot_q);
					out_count_d  = 5'(count_q);
					out_head_d   = head_q.none ? 5'h1f : 5'(head_q.idx);
					out_tail_d   = tail_q.none ? 5'h1f : 5'(tail_q.idx);
					state_d      = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// node memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			head_q      <= LINK_NONE;
			tail_q      <= LINK_NONE;
			count_q     <= '0;
			hint_q      <= '0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_idx_q   <= clr_idx_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			hint_q      <= hint_d;
			scan_idx_q  <= scan_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		func_q       <= func_d;
		value_q      <= value_d;
		sel_q        <= sel_d;
		node_q       <= node_d;
		nb_idx_q     <= nb_idx_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_slot_q   <= res_slot_d;
		out_status_q <= out_status_d;
		out_value_q  <= out_value_d;
		out_slot_q   <= out_slot_d;
		out_count_q  <= out_count_d;
		out_head_q   <= out_head_d;
		out_tail_q   <= out_tail_d;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign value_out   = out_value_q;
	assign slot_used   = out_slot_q;
	assign entry_count = out_count_q;
	assign head_slot   = out_head_q;
	assign tail_slot   = out_tail_q;

	// checks
	`PDLQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(NODE_COUNT),
		"entry count above pool size")
	`PDLQ_ASSERT_ALWAYS(a_head_empty, clk, arst_n, (count_q == '0) == head_q.none,
		"head link disagrees with entry count")
	`PDLQ_ASSERT_ALWAYS(a_tail_empty, clk, arst_n, (count_q == '0) == tail_q.none,
		"tail link disagrees with entry count")
	`PDLQ_ASSERT_IMPL(a_scan_has_room, clk, arst_n, state_q == ST_SCAN,
		count_q < CW'(NODE_COUNT), "free slot scan with full pool")

endmodule

`default_nettype wire
